[rtl/core/terrain_slope_aspect_3x3_unit_macros.svh]
// ----------------------------------------------------------------------------
// terrain slope/aspect assertion macros
// shared concurrent assertion forms, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef TERRAIN_SLOPE_ASPECT_3X3_UNIT_MACROS_SVH
`define TERRAIN_SLOPE_ASPECT_3X3_UNIT_MACROS_SVH
`ifndef SYNTH
// pre implies post in the same cycle
`define TSA_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// pre implies post after the delay given by dly
`define TSA_ASSERT_DLY(label, clk, rst_n, pre, dly, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> ##dly (post)) \
        else $error(msg);
`else
`define TSA_ASSERT_IMP(label, clk, rst_n, pre, post, msg)
`define TSA_ASSERT_DLY(label, clk, rst_n, pre, dly, post, msg)
`endif
`endif

[rtl/core/tsa_pkg.sv]
// ----------------------------------------------------------------------------
// tsa_pkg
// types, constants and the arctangent table of the slope/aspect unit
// ----------------------------------------------------------------------------
package tsa_pkg;

    localparam int ELEV_BITS  = 16;
    localparam int GRAD_W     = ELEV_BITS + 3;
    localparam int ABS_W      = ELEV_BITS + 2;
    localparam int FRAC_SHIFT = 29;
    localparam int QUOT_W     = ABS_W + FRAC_SHIFT;
    localparam int DIV_W      = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_W      = 32;
    localparam int VEC_W      = 64;
    localparam int SH_W       = 7;
    localparam int ANG_W      = 34;
    localparam int PROD_W     = 61;
    localparam int DEG_W      = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEV_NODATA   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_NODATA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ASPECT_NODATA = 3'd4;

    localparam logic [DIV_W-1:0]            CELL_RESET    = 32'd65536;
    localparam logic signed [ELEV_BITS-1:0] ELEV_ND_RESET = -16'sd32768;
    localparam logic signed [OUT_W-1:0]     OUT_ND_RESET  = 32'sh8000_0000;

    localparam logic [29:0]          DEG_PER_RAD_Q24 = 30'd961263669;
    localparam logic [VEC_W-1:0]     CORDIC_GAIN_Q30 = 64'd1768195363;
    localparam logic [30:0]          HALF_PI_Q30     = 31'd1686629713;
    localparam logic signed [7:0]    SLOPE_BIAS      = 8'sd14;
    localparam logic [5:0]           NORM_TOP        = 6'd60;
    localparam logic signed [OUT_W-1:0] Q16_90       = 32'sd5898240;
    localparam logic signed [OUT_W-1:0] Q16_180      = 32'sd11796480;
    localparam logic signed [OUT_W-1:0] Q16_270      = 32'sd17694720;
    localparam logic signed [OUT_W-1:0] Q16_360      = 32'sd23592960;
    localparam logic signed [OUT_W-1:0] FLAT_ASPECT  = -32'sd65536;

    typedef struct packed {
        logic signed [ELEV_BITS-1:0] center_elev;
        logic signed [ELEV_BITS-1:0] top_left_elev;
        logic signed [ELEV_BITS-1:0] top_mid_elev;
        logic signed [ELEV_BITS-1:0] top_right_elev;
        logic signed [ELEV_BITS-1:0] mid_left_elev;
        logic signed [ELEV_BITS-1:0] mid_right_elev;
        logic signed [ELEV_BITS-1:0] bottom_left_elev;
        logic signed [ELEV_BITS-1:0] bottom_mid_elev;
        logic signed [ELEV_BITS-1:0] bottom_right_elev;
    } t_req;

    typedef struct packed {
        logic signed [OUT_W-1:0] slope_deg;
        logic signed [OUT_W-1:0] aspect_deg;
        logic                    nodata_hit;
        logic                    flat_cell;
    } t_res;

    typedef struct packed {
        logic dx_neg;
        logic dx_pos;
        logic dy_neg;
        logic hit;
    } t_grad_tag;

    typedef struct packed {
        logic hit;
        logic flat;
        logic az_neg;
        logic az_pos;
        logic bz_neg;
    } t_ang_tag;

    typedef struct packed {
        t_ang_tag                ang;
        logic signed [SH_W-1:0]  sh;
    } t_c1_tag;

    typedef struct packed {
        logic                    hit;
        logic                    flat;
        logic signed [OUT_W-1:0] aspect;
    } t_fin_tag;

    // atan(2^-i) in Q30 radians
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] a;
        unique case (idx)
            5'd0:  a = 30'd843314857;
            5'd1:  a = 30'd497837829;
            5'd2:  a = 30'd263043837;
            5'd3:  a = 30'd133525159;
            5'd4:  a = 30'd67021687;
            5'd5:  a = 30'd33543516;
            5'd6:  a = 30'd16775851;
            5'd7:  a = 30'd8388437;
            5'd8:  a = 30'd4194283;
            5'd9:  a = 30'd2097149;
            5'd10: a = 30'd1048576;
            5'd11: a = 30'd524288;
            5'd12: a = 30'd262144;
            5'd13: a = 30'd131072;
            5'd14: a = 30'd65536;
            5'd15: a = 30'd32768;
            5'd16: a = 30'd16384;
            5'd17: a = 30'd8192;
            5'd18: a = 30'd4096;
            5'd19: a = 30'd2048;
            5'd20: a = 30'd1024;
            5'd21: a = 30'd512;
            5'd22: a = 30'd256;
            5'd23: a = 30'd128;
            5'd24: a = 30'd64;
            5'd25: a = 30'd32;
            5'd26: a = 30'd16;
            5'd27: a = 30'd8;
            5'd28: a = 30'd4;
            5'd29: a = 30'd2;
            5'd30: a = 30'd1;
            5'd31: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage

[rtl/core/tsa_hdiv.sv]
// ----------------------------------------------------------------------------
// tsa_hdiv
// two-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module tsa_hdiv #(
    parameter int TAG_W = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [tsa_pkg::ABS_W-1:0]   i_ax,
    input  logic [tsa_pkg::ABS_W-1:0]   i_ay,
    input  logic [tsa_pkg::DIV_W-1:0]   i_dvx,
    input  logic [tsa_pkg::DIV_W-1:0]   i_dvy,
    input  logic [TAG_W-1:0]            i_tag,
    output logic                        o_valid,
    output logic [tsa_pkg::QUOT_W-1:0]  o_gx,
    output logic [tsa_pkg::QUOT_W-1:0]  o_gy,
    output logic [TAG_W-1:0]            o_tag
);
    import tsa_pkg::*;

    logic                r_v   [QUOT_W];
    logic [DIV_W-1:0]    r_rx  [QUOT_W];
    logic [DIV_W-1:0]    r_ry  [QUOT_W];
    logic [QUOT_W-1:0]   r_qx  [QUOT_W];
    logic [QUOT_W-1:0]   r_qy  [QUOT_W];
    logic [TAG_W-1:0]    r_tag [QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++) begin : g_st
        logic              v_in;
        logic [DIV_W-1:0]  rx_in, ry_in;
        logic [QUOT_W-1:0] qx_in, qy_in;
        logic [TAG_W-1:0]  t_in;
        logic [DIV_W:0]    n_dx, n_dy;

        if (k == 0) begin : g_first
            assign v_in  = i_valid;
            assign rx_in = '0;
            assign ry_in = '0;
            assign qx_in = {i_ax, {FRAC_SHIFT{1'b0}}};
            assign qy_in = {i_ay, {FRAC_SHIFT{1'b0}}};
            assign t_in  = i_tag;
        end else begin : g_next
            assign v_in  = r_v[k-1];
            assign rx_in = r_rx[k-1];
            assign ry_in = r_ry[k-1];
            assign qx_in = r_qx[k-1];
            assign qy_in = r_qy[k-1];
            assign t_in  = r_tag[k-1];
        end

        // trial subtract of the divisor from the partial remainder
        assign n_dx = {rx_in, qx_in[QUOT_W-1]} - {1'b0, i_dvx};
        assign n_dy = {ry_in, qy_in[QUOT_W-1]} - {1'b0, i_dvy};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[k] <= t_in;
            if (!n_dx[DIV_W]) begin
                r_rx[k] <= n_dx[DIV_W-1:0];
                r_qx[k] <= {qx_in[QUOT_W-2:0], 1'b1};
            end else begin
                r_rx[k] <= {rx_in[DIV_W-2:0], qx_in[QUOT_W-1]};
                r_qx[k] <= {qx_in[QUOT_W-2:0], 1'b0};
            end
            if (!n_dy[DIV_W]) begin
                r_ry[k] <= n_dy[DIV_W-1:0];
                r_qy[k] <= {qy_in[QUOT_W-2:0], 1'b1};
            end else begin
                r_ry[k] <= {ry_in[DIV_W-2:0], qy_in[QUOT_W-1]};
                r_qy[k] <= {qy_in[QUOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_v[QUOT_W-1];
    assign o_gx    = r_qx[QUOT_W-1];
    assign o_gy    = r_qy[QUOT_W-1];
    assign o_tag   = r_tag[QUOT_W-1];

endmodule

[rtl/core/tsa_norm.sv]
// ----------------------------------------------------------------------------
// tsa_norm
// three-stage normalizer: leading-one search and common shift of a pair
// ----------------------------------------------------------------------------
module tsa_norm #(
    parameter int TAG_W = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [tsa_pkg::VEC_W-1:0]         i_x,
    input  logic [tsa_pkg::VEC_W-1:0]         i_y,
    input  logic [TAG_W-1:0]                  i_tag,
    output logic                              o_valid,
    output logic [tsa_pkg::VEC_W-1:0]         o_x,
    output logic [tsa_pkg::VEC_W-1:0]         o_y,
    output logic signed [tsa_pkg::SH_W-1:0]   o_sh,
    output logic [TAG_W-1:0]                  o_tag
);
    import tsa_pkg::*;

    localparam int GRP = VEC_W / 8;

    // stage a: per-byte leading one
    logic               r_a_v;
    logic [VEC_W-1:0]   r_a_x, r_a_y;
    logic [GRP-1:0]     r_a_nz;
    logic [2:0]         r_a_pos [GRP];
    logic [TAG_W-1:0]   r_a_tag;
    logic [VEC_W-1:0]   n_m;
    logic [2:0]         n_pos [GRP];

    // stage b: shift amount
    logic                    r_b_v;
    logic [VEC_W-1:0]        r_b_x, r_b_y;
    logic signed [SH_W-1:0]  r_b_sh;
    logic [TAG_W-1:0]        r_b_tag;
    logic [5:0]              n_p;
    logic signed [SH_W-1:0]  n_sh;

    // stage c: shifted pair
    logic                    r_c_v;
    logic [VEC_W-1:0]        r_c_x, r_c_y;
    logic signed [SH_W-1:0]  r_c_sh;
    logic [TAG_W-1:0]        r_c_tag;
    logic [SH_W-1:0]         n_rsh;

    assign n_m = i_x | i_y;

    always_comb begin
        for (int g = 0; g < GRP; g++) begin
            n_pos[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (n_m[8*g+b]) n_pos[g] = 3'(b);
            end
        end
    end

    always_comb begin
        n_p = 6'd0;
        for (int g = 0; g < GRP; g++) begin
            if (r_a_nz[g]) n_p = {3'(g), r_a_pos[g]};
        end
        if (r_a_nz == '0) begin
            n_sh = '0;
        end else begin
            n_sh = SH_W'($signed({1'b0, NORM_TOP}) - $signed({1'b0, n_p}));
        end
    end

    assign n_rsh = SH_W'(-r_b_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_x   <= i_x;
        r_a_y   <= i_y;
        r_a_tag <= i_tag;
        for (int g = 0; g < GRP; g++) begin
            r_a_nz[g]  <= |n_m[8*g +: 8];
            r_a_pos[g] <= n_pos[g];
        end

        r_b_x   <= r_a_x;
        r_b_y   <= r_a_y;
        r_b_sh  <= n_sh;
        r_b_tag <= r_a_tag;

        if (r_b_sh[SH_W-1]) begin
            r_c_x <= r_b_x >> n_rsh;
            r_c_y <= r_b_y >> n_rsh;
        end else begin
            r_c_x <= r_b_x << r_b_sh[SH_W-2:0];
            r_c_y <= r_b_y << r_b_sh[SH_W-2:0];
        end
        r_c_sh  <= r_b_sh;
        r_c_tag <= r_b_tag;
    end

    assign o_valid = r_c_v;
    assign o_x     = r_c_x;
    assign o_y     = r_c_y;
    assign o_sh    = r_c_sh;
    assign o_tag   = r_c_tag;

endmodule

[rtl/core/tsa_cordic.sv]
// ----------------------------------------------------------------------------
// tsa_cordic
// pipelined vectoring cordic, then clamp and radian to degree conversion
// ----------------------------------------------------------------------------
module tsa_cordic #(
    parameter int STAGES = 20,
    parameter int TAG_W  = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [tsa_pkg::VEC_W-1:0]         i_x,
    input  logic [tsa_pkg::VEC_W-1:0]         i_y,
    input  logic [TAG_W-1:0]                  i_tag,
    output logic                              o_valid,
    output logic [tsa_pkg::VEC_W-1:0]         o_mag,
    output logic signed [tsa_pkg::OUT_W-1:0]  o_deg,
    output logic [TAG_W-1:0]                  o_tag
);
    import tsa_pkg::*;

    logic                    r_v   [STAGES];
    logic [VEC_W-1:0]        r_x   [STAGES];
    logic [VEC_W-1:0]        r_y   [STAGES];
    logic signed [ANG_W-1:0] r_z   [STAGES];
    logic [TAG_W-1:0]        r_tag [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_st
        logic                    v_in;
        logic [VEC_W-1:0]        x_in, y_in, n_xs, n_ys;
        logic signed [ANG_W-1:0] z_in, n_at;
        logic [TAG_W-1:0]        t_in;

        if (k == 0) begin : g_first
            assign v_in = i_valid;
            assign x_in = i_x;
            assign y_in = i_y;
            assign z_in = '0;
            assign t_in = i_tag;
        end else begin : g_next
            assign v_in = r_v[k-1];
            assign x_in = r_x[k-1];
            assign y_in = r_y[k-1];
            assign z_in = r_z[k-1];
            assign t_in = r_tag[k-1];
        end

        assign n_xs = VEC_W'($signed(x_in) >>> k);
        assign n_ys = VEC_W'($signed(y_in) >>> k);
        assign n_at = $signed({{(ANG_W-30){1'b0}}, atan_q30(5'(k))});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[k] <= t_in;
            if (y_in[VEC_W-1]) begin
                r_x[k] <= x_in - n_ys;
                r_y[k] <= y_in + n_xs;
                r_z[k] <= z_in - n_at;
            end else begin
                r_x[k] <= x_in + n_ys;
                r_y[k] <= y_in - n_xs;
                r_z[k] <= z_in + n_at;
            end
        end
    end

    // clamp to the first quadrant and scale to degrees
    logic                r_m_v;
    logic [PROD_W-1:0]   r_m_prod;
    logic [VEC_W-1:0]    r_m_mag;
    logic [TAG_W-1:0]    r_m_tag;
    logic [30:0]         n_zc;

    logic                r_d_v;
    logic [DEG_W-1:0]    r_d_deg;
    logic [VEC_W-1:0]    r_d_mag;
    logic [TAG_W-1:0]    r_d_tag;
    logic [PROD_W:0]     n_round;

    always_comb begin
        if (r_z[STAGES-1] < 0) begin
            n_zc = '0;
        end else if (r_z[STAGES-1] > $signed({{(ANG_W-31){1'b0}}, HALF_PI_Q30})) begin
            n_zc = HALF_PI_Q30;
        end else begin
            n_zc = r_z[STAGES-1][30:0];
        end
    end

    assign n_round = {1'b0, r_m_prod} + ((PROD_W+1)'(1) << 37);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            r_m_v <= r_v[STAGES-1];
            r_d_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_prod <= PROD_W'(n_zc) * PROD_W'(DEG_PER_RAD_Q24);
        r_m_mag  <= r_x[STAGES-1];
        r_m_tag  <= r_tag[STAGES-1];
        r_d_deg  <= n_round[38 +: DEG_W];
        r_d_mag  <= r_m_mag;
        r_d_tag  <= r_m_tag;
    end

    assign o_valid = r_d_v;
    assign o_mag   = r_d_mag;
    assign o_deg   = $signed({{(OUT_W-DEG_W){1'b0}}, r_d_deg});
    assign o_tag   = r_d_tag;

endmodule

[rtl/core/terrain_slope_aspect_3x3_unit.sv]
// path from start to result strobe: the input stage, the 47-stage divider, two normalizers,
//   two cordic pipelines, the prep stage and the output stage
// throughput: one request per cycle, busy never rises; results cannot be stalled
// reset: synchronous active-low i_rst_n flushes every in-flight request and
//   restores the configuration registers to their reset values
// ----------------------------------------------------------------------------
// terrain_slope_aspect_3x3_unit
// horn slope and aspect of a 3x3 elevation window, fully pipelined
// ----------------------------------------------------------------------------
`include "terrain_slope_aspect_3x3_unit_macros.svh"

module terrain_slope_aspect_3x3_unit #(
    parameter int CORDIC_STAGES = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  tsa_pkg::t_req                  i_req,
    output logic                           o_res_valid,
    output tsa_pkg::t_res                  o_res,
    input  logic                           i_cfg_we,
    input  logic [tsa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tsa_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import tsa_pkg::*;

    localparam int LAT = QUOT_W + 2 * CORDIC_STAGES + 13;

    // configuration registers
    logic [DIV_W-1:0]            r_cell_w, r_cell_h;
    logic signed [ELEV_BITS-1:0] r_elev_nd;
    logic signed [OUT_W-1:0]     r_slope_nd, r_aspect_nd;
    logic [DIV_W-1:0]            n_dvx, n_dvy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_w    <= CELL_RESET;
            r_cell_h    <= CELL_RESET;
            r_elev_nd   <= ELEV_ND_RESET;
            r_slope_nd  <= OUT_ND_RESET;
            r_aspect_nd <= OUT_ND_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CELL_WIDTH:    r_cell_w    <= i_cfg_wdata;
                CFG_CELL_HEIGHT:   r_cell_h    <= i_cfg_wdata;
                CFG_ELEV_NODATA:   r_elev_nd   <= $signed(i_cfg_wdata[ELEV_BITS-1:0]);
                CFG_SLOPE_NODATA:  r_slope_nd  <= $signed(i_cfg_wdata);
                CFG_ASPECT_NODATA: r_aspect_nd <= $signed(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // zero cell size divides as one
    assign n_dvx = (r_cell_w == '0) ? DIV_W'(1) : r_cell_w;
    assign n_dvy = (r_cell_h == '0) ? DIV_W'(1) : r_cell_h;

    // never busy: a new request may enter every cycle
    logic n_accept;
    assign o_busy   = 1'b0;
    assign n_accept = i_start && !o_busy;

    // ---------------- stage 1: horn gradients and nodata check
    logic signed [GRAD_W-1:0] n_dx, n_dy;
    logic                     n_hit;
    logic                     r_s1_v;
    logic [ABS_W-1:0]         r_s1_ax, r_s1_ay;
    t_grad_tag                r_s1_tag;

    // west minus east, south minus north
    assign n_dx = (GRAD_W'(i_req.top_left_elev) + (GRAD_W'(i_req.mid_left_elev) <<< 1)
                   + GRAD_W'(i_req.bottom_left_elev))
                - (GRAD_W'(i_req.top_right_elev) + (GRAD_W'(i_req.mid_right_elev) <<< 1)
                   + GRAD_W'(i_req.bottom_right_elev));
    assign n_dy = (GRAD_W'(i_req.bottom_left_elev) + (GRAD_W'(i_req.bottom_mid_elev) <<< 1)
                   + GRAD_W'(i_req.bottom_right_elev))
                - (GRAD_W'(i_req.top_left_elev) + (GRAD_W'(i_req.top_mid_elev) <<< 1)
                   + GRAD_W'(i_req.top_right_elev));

    assign n_hit = (i_req.center_elev == r_elev_nd) || (i_req.top_left_elev == r_elev_nd)
                || (i_req.top_mid_elev == r_elev_nd) || (i_req.top_right_elev == r_elev_nd)
                || (i_req.mid_left_elev == r_elev_nd) || (i_req.mid_right_elev == r_elev_nd)
                || (i_req.bottom_left_elev == r_elev_nd)
                || (i_req.bottom_mid_elev == r_elev_nd)
                || (i_req.bottom_right_elev == r_elev_nd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= n_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ax         <= n_dx[GRAD_W-1] ? ABS_W'(-n_dx) : ABS_W'(n_dx);
        r_s1_ay         <= n_dy[GRAD_W-1] ? ABS_W'(-n_dy) : ABS_W'(n_dy);
        r_s1_tag.dx_neg <= n_dx < 0;
        r_s1_tag.dx_pos <= n_dx > 0;
        r_s1_tag.dy_neg <= n_dy < 0;
        r_s1_tag.hit    <= n_hit;
    end

    // ---------------- gradient scaling: |d| * 2^29 / (cell size)
    logic               w_div_v;
    logic [QUOT_W-1:0]  w_gx, w_gy;
    t_grad_tag          w_div_tag;
    t_ang_tag           n_ang;

    tsa_hdiv #(
        .TAG_W ($bits(t_grad_tag))
    ) u_hdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_v),
        .i_ax    (r_s1_ax),
        .i_ay    (r_s1_ay),
        .i_dvx   (n_dvx),
        .i_dvy   (n_dvy),
        .i_tag   (r_s1_tag),
        .o_valid (w_div_v),
        .o_gx    (w_gx),
        .o_gy    (w_gy),
        .o_tag   (w_div_tag)
    );

    // quadrant flags: a gradient that truncates to zero counts as zero
    always_comb begin
        n_ang.hit    = w_div_tag.hit;
        n_ang.flat   = (w_gx == '0) && (w_gy == '0);
        n_ang.az_neg = (w_gx != '0) && w_div_tag.dx_neg;
        n_ang.az_pos = (w_gx != '0) && w_div_tag.dx_pos;
        n_ang.bz_neg = (w_gy != '0) && w_div_tag.dy_neg;
    end

    // ---------------- first normalize + cordic: direction angle and magnitude
    logic                    w_n1_v;
    logic [VEC_W-1:0]        w_n1_x, w_n1_y;
    logic signed [SH_W-1:0]  w_n1_sh;
    t_ang_tag                w_n1_tag;
    t_c1_tag                 n_c1_tag;

    tsa_norm #(
        .TAG_W ($bits(t_ang_tag))
    ) u_norm_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_v),
        .i_x     (VEC_W'(w_gx)),
        .i_y     (VEC_W'(w_gy)),
        .i_tag   (n_ang),
        .o_valid (w_n1_v),
        .o_x     (w_n1_x),
        .o_y     (w_n1_y),
        .o_sh    (w_n1_sh),
        .o_tag   (w_n1_tag)
    );

    assign n_c1_tag.ang = w_n1_tag;
    assign n_c1_tag.sh  = w_n1_sh;

    logic                    w_c1_v;
    logic [VEC_W-1:0]        w_c1_mag;
    logic signed [OUT_W-1:0] w_c1_theta;
    t_c1_tag                 w_c1_tag;

    tsa_cordic #(
        .STAGES (CORDIC_STAGES),
        .TAG_W  ($bits(t_c1_tag))
    ) u_cordic_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_n1_v),
        .i_x     (w_n1_x),
        .i_y     (w_n1_y),
        .i_tag   (n_c1_tag),
        .o_valid (w_c1_v),
        .o_mag   (w_c1_mag),
        .o_deg   (w_c1_theta),
        .o_tag   (w_c1_tag)
    );

    // ---------------- prep stage: slope operands and aspect in degrees
    logic signed [7:0]       n_d;
    logic [5:0]              n_damt;
    logic signed [OUT_W-1:0] n_asp_q, n_asp_s;
    logic                    r_p_v;
    logic [VEC_W-1:0]        r_p_sx, r_p_sy;
    t_fin_tag                r_p_tag;

    // gradient magnitude is mag * 2^(14-sh) in Q30 units relative to the gain
    assign n_d    = SLOPE_BIAS - 8'(w_c1_tag.sh);
    assign n_damt = n_d[7] ? 6'(-n_d) : n_d[5:0];

    always_comb begin
        priority if (w_c1_tag.ang.az_neg) begin
            n_asp_q = w_c1_tag.ang.bz_neg ? Q16_90 - w_c1_theta : Q16_90 + w_c1_theta;
        end else if (w_c1_tag.ang.az_pos) begin
            n_asp_q = w_c1_tag.ang.bz_neg ? Q16_270 + w_c1_theta : Q16_270 - w_c1_theta;
        end else begin
            n_asp_q = w_c1_tag.ang.bz_neg ? '0 : Q16_180;
        end
        // rotate by half a turn, wrap into [0, 360)
        n_asp_s = n_asp_q + Q16_180;
        if (n_asp_s >= Q16_360) n_asp_s = n_asp_s - Q16_360;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else begin
            r_p_v <= w_c1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_d[7]) begin
            r_p_sx <= CORDIC_GAIN_Q30;
            r_p_sy <= w_c1_mag >> n_damt;
        end else begin
            r_p_sx <= CORDIC_GAIN_Q30 >> n_damt;
            r_p_sy <= w_c1_mag;
        end
        r_p_tag.hit    <= w_c1_tag.ang.hit;
        r_p_tag.flat   <= w_c1_tag.ang.flat;
        r_p_tag.aspect <= n_asp_s;
    end

    // ---------------- second normalize + cordic: slope = atan(magnitude)
    logic                    w_n2_v;
    logic [VEC_W-1:0]        w_n2_x, w_n2_y;
    t_fin_tag                w_n2_tag;

    tsa_norm #(
        .TAG_W ($bits(t_fin_tag))
    ) u_norm_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p_v),
        .i_x     (r_p_sx),
        .i_y     (r_p_sy),
        .i_tag   (r_p_tag),
        .o_valid (w_n2_v),
        .o_x     (w_n2_x),
        .o_y     (w_n2_y),
        .o_sh    (),
        .o_tag   (w_n2_tag)
    );

    logic                    w_c2_v;
    logic signed [OUT_W-1:0] w_c2_slope;
    t_fin_tag                w_c2_tag;

    tsa_cordic #(
        .STAGES (CORDIC_STAGES),
        .TAG_W  ($bits(t_fin_tag))
    ) u_cordic_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_n2_v),
        .i_x     (w_n2_x),
        .i_y     (w_n2_y),
        .i_tag   (w_n2_tag),
        .o_valid (w_c2_v),
        .o_mag   (),
        .o_deg   (w_c2_slope),
        .o_tag   (w_c2_tag)
    );

    // ---------------- output stage: nodata and flat overrides
    logic  r_res_v;
    t_res  r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_v <= 1'b0;
        end else begin
            r_res_v <= w_c2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (w_c2_tag.hit) begin
            r_res.slope_deg  <= r_slope_nd;
            r_res.aspect_deg <= r_aspect_nd;
            r_res.nodata_hit <= 1'b1;
            r_res.flat_cell  <= 1'b0;
        end else if (w_c2_tag.flat) begin
            r_res.slope_deg  <= '0;
            r_res.aspect_deg <= FLAT_ASPECT;
            r_res.nodata_hit <= 1'b0;
            r_res.flat_cell  <= 1'b1;
        end else begin
            r_res.slope_deg  <= w_c2_slope;
            r_res.aspect_deg <= w_c2_tag.aspect;
            r_res.nodata_hit <= 1'b0;
            r_res.flat_cell  <= 1'b0;
        end
    end

    assign o_res_valid = r_res_v;
    assign o_res       = r_res;

    // ---------------- assertions
    `TSA_ASSERT_DLY(a_latency, i_clk, i_rst_n, n_accept, LAT, o_res_valid,
        "result strobe missing")
    `TSA_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_res_valid,
        !(o_res.nodata_hit && o_res.flat_cell), "nodata and flat both set")
    `TSA_ASSERT_IMP(a_aspect, i_clk, i_rst_n,
        o_res_valid && !o_res.nodata_hit && !o_res.flat_cell,
        (o_res.aspect_deg >= 0) && (o_res.aspect_deg < Q16_360), "aspect out of range")

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the horn slope/aspect unit: random and directed
// windows under several register settings, results checked against a
// bit-exact cordic predictor kept in a small scoreboard class
// ----------------------------------------------------------------------------
module tb;
    import tsa_pkg::*;

    // slope/aspect predictor and store of expected results
    class slope_scoreboard;
        logic [31:0]          cell_w;
        logic [31:0]          cell_h;
        logic signed [15:0]   elev_nd;
        logic [31:0]          slope_nd;
        logic [31:0]          aspect_nd;
        t_res                 expected_q[$];
        int                   errors;
        longint               atan_lut[20];

        function new();
            atan_lut = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149,
                         1048576, 524288, 262144, 131072, 65536, 32768,
                         16384, 8192, 4096, 2048};
            cell_w    = 32'd65536;
            cell_h    = 32'd65536;
            elev_nd   = -16'sd32768;
            slope_nd  = 32'h8000_0000;
            aspect_nd = 32'h8000_0000;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_CELL_WIDTH:    cell_w = val;
                CFG_CELL_HEIGHT:   cell_h = val;
                CFG_ELEV_NODATA:   elev_nd = val[15:0];
                CFG_SLOPE_NODATA:  slope_nd = val;
                CFG_ASPECT_NODATA: aspect_nd = val;
                default: ;
            endcase
        endfunction

        function longint unsigned asr(longint unsigned u, int s);
            return $unsigned($signed(u) >>> s);
        endfunction

        // first-quadrant vectoring, angle in q30 radians
        function longint vec_angle(longint unsigned xi, longint unsigned yi,
                                   output longint unsigned mag, output int sh);
            longint unsigned x, y, m, xs, ys;
            longint z;
            int p, l;
            x = xi; y = yi; z = 0; sh = 0;
            if ((x | y) != 0) begin
                m = x | y;
                p = 63;
                while (p > 0 && m[p] == 1'b0) p--;
                l = 60 - p;
                if (l > 0) begin
                    x = x << l; y = y << l;
                end else if (l < 0) begin
                    x = x >> (-l); y = y >> (-l);
                end
                sh = l;
            end
            for (int i = 0; i < 20; i++) begin
                xs = asr(x, i);
                ys = asr(y, i);
                if (y[63]) begin
                    x = x - ys; y = y + xs; z = z - atan_lut[i];
                end else begin
                    x = x + ys; y = y - xs; z = z + atan_lut[i];
                end
            end
            if (z < 0) z = 0;
            if (z > 64'sd1686629713) z = 64'sd1686629713;
            mag = x;
            return z;
        endfunction

        function longint rad_to_deg(longint z);
            longint unsigned p;
            p = longint'(z) * 64'd961263669 + (64'd1 << 37);
            return longint'(p >> 38);
        endfunction

        function t_res predict(t_req r);
            t_res res;
            longint v[9];
            longint dx, dy, theta, slope, asp;
            longint unsigned cw, ch, ax, ay, gx, gy, mag, sx, sy, dmag;
            int sh, dsh, d;
            bit hit;
            v = '{r.center_elev, r.top_left_elev, r.top_mid_elev, r.top_right_elev,
                  r.mid_left_elev, r.mid_right_elev, r.bottom_left_elev,
                  r.bottom_mid_elev, r.bottom_right_elev};
            hit = 0;
            foreach (v[i]) if (v[i] == longint'(elev_nd)) hit = 1;
            if (hit) begin
                res.slope_deg = slope_nd;
                res.aspect_deg = aspect_nd;
                res.nodata_hit = 1'b1;
                res.flat_cell = 1'b0;
                return res;
            end
            dx = (v[1] + 2 * v[4] + v[6]) - (v[3] + 2 * v[5] + v[8]);
            dy = (v[6] + 2 * v[7] + v[8]) - (v[1] + 2 * v[2] + v[3]);
            // zero cell size counts as one
            cw = (cell_w != 0) ? cell_w : 1;
            ch = (cell_h != 0) ? cell_h : 1;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            gx = (ax << 29) / cw;
            gy = (ay << 29) / ch;
            if (gx == 0 && gy == 0) begin
                res.slope_deg = FLAT_ASPECT * 0;
                res.aspect_deg = FLAT_ASPECT;
                res.nodata_hit = 1'b0;
                res.flat_cell = 1'b1;
                return res;
            end
            theta = rad_to_deg(vec_angle(gx, gy, mag, sh));
            // slope angle from magnitude against the cordic gain
            d = 14 - sh;
            sy = mag;
            sx = 64'd1768195363;
            if (d >= 0) sx = (d < 64) ? sx >> d : 0;
            else        sy = (-d < 64) ? sy >> (-d) : 0;
            slope = 0;
            if ((sx | sy) != 0) slope = rad_to_deg(vec_angle(sx, sy, dmag, dsh));
            // quadrant rules; a gradient truncated to zero counts as zero
            if (gx != 0 && dx < 0)
                asp = (gy != 0 && dy < 0) ? Q16_90 - theta : Q16_90 + theta;
            else if (gx != 0 && dx > 0)
                asp = (gy != 0 && dy < 0) ? Q16_270 + theta : Q16_270 - theta;
            else
                asp = (gy != 0 && dy < 0) ? 0 : Q16_180;
            asp += Q16_180;
            if (asp >= Q16_360) asp -= Q16_360;
            res.slope_deg = slope[31:0];
            res.aspect_deg = asp[31:0];
            res.nodata_hit = 1'b0;
            res.flat_cell = 1'b0;
            return res;
        endfunction

        function void note_request(t_req r);
            expected_q.push_back(predict(r));
        endfunction

        function void check_result(t_res got);
            t_res exp_r;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding: %h", got);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.slope_deg !== exp_r.slope_deg) begin
                $error("slope_deg expected %0d got %0d", exp_r.slope_deg, got.slope_deg);
                errors++;
            end
            if (got.aspect_deg !== exp_r.aspect_deg) begin
                $error("aspect_deg expected %0d got %0d", exp_r.aspect_deg, got.aspect_deg);
                errors++;
            end
            if (got.nodata_hit !== exp_r.nodata_hit) begin
                $error("nodata_hit expected %0b got %0b", exp_r.nodata_hit, got.nodata_hit);
                errors++;
            end
            if (got.flat_cell !== exp_r.flat_cell) begin
                $error("flat_cell expected %0b got %0b", exp_r.flat_cell, got.flat_cell);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    t_req                  i_req;
    logic                  o_res_valid;
    t_res                  o_res;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]      i_cfg_wdata;

    slope_scoreboard sb;

    terrain_slope_aspect_3x3_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // requests and results are both sampled at the edge that accepts them
    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy) sb.note_request(i_req);
        if (i_rst_n && o_res_valid) sb.check_result(o_res);
    end

    // burst mode keeps start high back to back
    bit burst;

    task automatic send_request(t_req r);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // quiesce: all results back, then pipeline latency plus margin
    task automatic drain();
        i_start <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [31:0] cw, logic [31:0] ch, logic signed [15:0] nd,
                             logic [31:0] snd, logic [31:0] and_v);
        write_reg(CFG_CELL_WIDTH, cw);
        write_reg(CFG_CELL_HEIGHT, ch);
        write_reg(CFG_ELEV_NODATA, {{16{nd[15]}}, nd});
        write_reg(CFG_SLOPE_NODATA, snd);
        write_reg(CFG_ASPECT_NODATA, and_v);
    endtask

    function automatic t_req win(int c, int tl, int tm, int tr, int ml, int mr,
                                 int bl, int bm, int br);
        t_req r;
        r = '{c[15:0], tl[15:0], tm[15:0], tr[15:0], ml[15:0], mr[15:0],
              bl[15:0], bm[15:0], br[15:0]};
        return r;
    endfunction

    // mostly smooth terrain around a random base, some raw noise and nodata
    function automatic t_req random_window();
        t_req r;
        logic [15:0] cells[9];
        int base, spread, kind;
        kind = $urandom_range(0, 99);
        base = $signed(16'($urandom));
        case ($urandom_range(0, 3))
            0: spread = 2;
            1: spread = 60;
            2: spread = 3000;
            default: spread = 30000;
        endcase
        foreach (cells[i]) begin
            if (kind < 20) cells[i] = 16'($urandom);
            else if (kind < 30) cells[i] = base[15:0];
            else cells[i] = 16'(base + $urandom_range(0, 2 * spread) - spread);
        end
        if (kind >= 88) cells[$urandom_range(0, 8)] = sb.elev_nd;
        r = '{cells[0], cells[1], cells[2], cells[3], cells[4], cells[5],
              cells[6], cells[7], cells[8]};
        return r;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) burst = ~burst;
            send_request(random_window());
        end
        burst = 0;
    endtask

    initial begin
        sb = new();
        burst = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed windows at reset settings
        send_request(win(5, 5, 5, 5, 5, 5, 5, 5, 5));           // flat
        send_request(win(0, 10, 0, -10, 10, -10, 10, 0, -10));  // dx positive
        send_request(win(0, -10, 0, 10, -10, 10, -10, 0, 10));  // dx negative
        send_request(win(0, 10, 10, 10, 0, 0, -10, -10, -10));  // dy negative
        send_request(win(0, -10, -10, -10, 0, 0, 10, 10, 10));  // dy positive
        send_request(win(0, 20, 10, 0, 10, -10, 0, -10, -20));  // diagonal
        send_request(win(0, 0, 10, 20, -10, 10, -20, -10, 0));
        send_request(win(0, 0, -10, -20, 10, -10, 20, 10, 0));
        send_request(win(0, -20, -10, 0, -10, 10, 0, 10, 20));
        send_request(win(0, 1, 0, 0, 0, 0, 0, 0, 0));           // smallest step
        send_request(win(0, 32767, -32767, -32767, 32767, -32767,
                         32767, 32767, -32767));                // steepest
        send_request(win(-32767, -32767, -32767, -32767, -32767, -32767,
                         -32767, -32767, -32767));
        send_request(win(32767, 32767, 32767, 32767, 32767, 32767,
                         32767, 32767, 32767));
        send_request(win(-32768, 1, 2, 3, 4, 5, 6, 7, 8));      // nodata center
        send_request(win(0, 1, 2, 3, 4, 5, 6, 7, -32768));      // nodata corner
        random_phase(100);
        drain();

        // smallest cells, nodata at the top of the range
        write_all(32'd1, 32'd0, 16'sd32767, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(win(32767, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(win(-32768, -32768, 32767, -32768, 32766, -32768,
                         -32768, 32766, -32768));
        random_phase(100);
        drain();

        // largest cells: small gradients truncate to zero
        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sd0, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(win(1, 1, 1, 1, 2, 1, 1, 1, 1));
        send_request(win(1, 32767, -32768, 32767, 32767, -32768,
                         32767, 32767, 32767));
        random_phase(100);
        drain();

        // uneven cells
        write_all(32'd30000, 32'd200000, -16'sd9999, 32'h1234_5678, 32'h8765_4321);
        random_phase(100);
        drain();

        write_all(32'd1966080, 32'd7, 16'sd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        random_phase(100);
        drain();

        if (sb.errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
